// File: src/frame_change_mse_detector_top_macros.svh
// Assertion macros used by the top-level file that checks the block.
`ifndef FRAME_CHANGE_MSE_DETECTOR_TOP_MACROS_SVH
`define FRAME_CHANGE_MSE_DETECTOR_TOP_MACROS_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define FCMD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold at the clock edge after the antecedent.
`define FCMD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/fcmd_pkg.sv
`default_nettype none

package fcmd_pkg;

   localparam int CHAN_W = 8;
   localparam int PIX_W = 3 * CHAN_W;
   localparam int SQ_W = 18;
   localparam int COUNT_W = 20;
   localparam int SUM_W = 37;
   localparam int THR_W = 18;
   localparam int LIMIT_W = THR_W + COUNT_W;
   localparam int CSR_W = 20;
   localparam int CSR_IDX_W = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PIXELS = 1'b1;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 18'd1;
   localparam logic [COUNT_W-1:0] FRAME_PIXELS_RESET = 20'd307200;

   localparam int DEF_MAX_PIXELS = 524288;
   localparam int DEF_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [CHAN_W-1:0] chan_blue;
      logic [CHAN_W-1:0] chan_green;
      logic [CHAN_W-1:0] chan_red;
      logic end_of_frame;
   } fcmd_req_type;

   typedef struct packed {
      logic frame_similar;
      logic size_mismatch;
      logic [SUM_W-1:0] error_sum;
   } fcmd_rsp_type;

   typedef struct packed {
      logic [SQ_W-1:0] sq_sum;
      logic last;
      logic mismatch;
      logic have_ref;
   } fcmd_entry_type;

   typedef struct packed {
      logic valid;
      logic swap;
      logic set_ref;
   } fcmd_done_type;

endpackage

`default_nettype wire

// File: src/fcmd_ram.sv
`default_nettype none

module fcmd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/fcmd_queue.sv
`default_nettype none

module fcmd_queue
   import fcmd_pkg::*;
#(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  fcmd_entry_type               push_entry,
   input  logic                         pop,
   output fcmd_entry_type               head,
   output logic                         not_empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   fcmd_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count = count_ff;

endmodule

`default_nettype wire

// File: src/fcmd_front.sv
`default_nettype none

module fcmd_front
   import fcmd_pkg::*;
#(
   parameter int MAX_PIXELS = DEF_MAX_PIXELS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fcmd_req_type                       req_word,
   input  logic [COUNT_W-1:0]                 frame_pixels,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count,
   input  fcmd_done_type                      done,
   output logic                               push,
   output fcmd_entry_type                     push_entry
);

   localparam int IDX_W = $clog2(MAX_PIXELS);
   localparam int ADDR_W = IDX_W + 1;
   localparam int RAM_DEPTH = 2 * (2 ** IDX_W);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [COUNT_W-1:0] pixel_count_ff, pixel_count_in;
   logic ref_bank_ff, ref_bank_in;
   logic have_ref_ff, have_ref_in;
   logic pending_ff, pending_in;
   logic s1_valid_ff, s1_valid_in;
   fcmd_req_type s1_pix_ff, s1_pix_in;
   logic s1_cmp_ff, s1_cmp_in;
   logic s1_mis_ff, s1_mis_in;

   logic accept;
   logic store;
   logic mismatch;
   logic queue_full;
   logic [IDX_W-1:0] idx_cut;
   logic ram_rd_en;
   logic ram_wr_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [PIX_W-1:0] ram_rd_data;
   logic [SQ_W-1:0] sq_total;

   function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'((2 * CHAN_W)'(d) * (2 * CHAN_W)'(d));
   endfunction

   assign queue_full = ({1'b0, queue_count} + (CNT_W + 1)'(s1_valid_ff))
                       >= (CNT_W + 1)'(QUEUE_DEPTH);
   assign req_stall = pending_ff || queue_full;
   assign accept = req_valid && !req_stall;

   assign idx_cut = IDX_W'(pixel_count_ff);
   assign store = 32'(pixel_count_ff) < 32'(MAX_PIXELS);
   assign mismatch = (pixel_count_ff == COUNT_MAX)
                     || (({1'b0, pixel_count_ff} + 1'b1) != {1'b0, frame_pixels})
                     || (32'(frame_pixels) > 32'(MAX_PIXELS));

   assign ram_rd_en = accept && store && have_ref_ff;
   assign ram_wr_en = accept && store;
   assign ram_rd_addr = {ref_bank_ff, idx_cut};
   assign ram_wr_addr = {~ref_bank_ff, idx_cut};

   fcmd_ram #(
      .WIDTH(PIX_W),
      .DEPTH(RAM_DEPTH)
   ) u_banks (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data({req_word.chan_red, req_word.chan_green, req_word.chan_blue}),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      pixel_count_in = pixel_count_ff;
      pending_in = pending_ff;
      ref_bank_in = ref_bank_ff;
      have_ref_in = have_ref_ff;
      if (accept) begin
         if (req_word.end_of_frame) begin
            pixel_count_in = '0;
            pending_in = 1'b1;
         end else if (pixel_count_ff != COUNT_MAX) begin
            pixel_count_in = pixel_count_ff + 1'b1;
         end
      end
      if (done.valid) begin
         pending_in = 1'b0;
         if (done.swap) begin
            ref_bank_in = ~ref_bank_ff;
         end
         if (done.set_ref) begin
            have_ref_in = 1'b1;
         end
      end
      s1_valid_in = accept;
      s1_pix_in = accept ? req_word : s1_pix_ff;
      s1_cmp_in = store && have_ref_ff;
      s1_mis_in = mismatch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= '0;
         pending_ff <= 1'b0;
         ref_bank_ff <= 1'b0;
         have_ref_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         pixel_count_ff <= pixel_count_in;
         pending_ff <= pending_in;
         ref_bank_ff <= ref_bank_in;
         have_ref_ff <= have_ref_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff <= s1_pix_in;
      s1_cmp_ff <= s1_cmp_in;
      s1_mis_ff <= s1_mis_in;
   end

   assign sq_total = chan_sq(s1_pix_ff.chan_blue, ram_rd_data[CHAN_W-1:0])
                   + chan_sq(s1_pix_ff.chan_green, ram_rd_data[2*CHAN_W-1:CHAN_W])
                   + chan_sq(s1_pix_ff.chan_red, ram_rd_data[3*CHAN_W-1:2*CHAN_W]);

   assign push = s1_valid_ff;

   always_comb begin
      push_entry.sq_sum = s1_cmp_ff ? sq_total : '0;
      push_entry.last = s1_pix_ff.end_of_frame;
      push_entry.mismatch = s1_mis_ff;
      push_entry.have_ref = have_ref_ff;
   end

endmodule

`default_nettype wire

// File: src/fcmd_back.sv
`default_nettype none

module fcmd_back
   import fcmd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_valid,
   input  fcmd_entry_type     queue_head,
   output logic               pop,
   input  logic [THR_W-1:0]   change_threshold,
   input  logic [COUNT_W-1:0] frame_pixels,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fcmd_rsp_type       rsp_word,
   output fcmd_done_type      done
);

   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic rsp_valid_ff, rsp_valid_in;
   fcmd_rsp_type rsp_word_ff, rsp_word_in;
   fcmd_done_type done_ff, done_in;

   logic [SUM_W:0] sum_wide;
   logic [SUM_W-1:0] sum_sat;
   logic within_limit;
   logic gives_result;

   assign limit_in = LIMIT_W'(change_threshold) * LIMIT_W'(frame_pixels);

   assign sum_wide = {1'b0, acc_ff} + (SUM_W + 1)'(queue_head.sq_sum);
   assign sum_sat = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
   assign within_limit = LIMIT_W'(sum_sat) <= limit_ff;

   assign gives_result = queue_head.last && (queue_head.mismatch || queue_head.have_ref);
   assign pop = queue_valid && (!gives_result || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      acc_in = acc_ff;
      if (pop) begin
         acc_in = queue_head.last ? '0 : sum_sat;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_word_in = rsp_word_ff;
      if (pop && gives_result) begin
         rsp_valid_in = 1'b1;
         rsp_word_in.frame_similar = !queue_head.mismatch && within_limit;
         rsp_word_in.size_mismatch = queue_head.mismatch;
         rsp_word_in.error_sum = sum_sat;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      done_in.valid = pop && queue_head.last;
      done_in.set_ref = !queue_head.mismatch;
      done_in.swap = !queue_head.mismatch && (!queue_head.have_ref || !within_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
         done_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: src/frame_change_mse_detector_top.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  fcmd_req_type, one pixel per word
// rsp       out        rsp_valid/rsp_stall  fcmd_rsp_type, one word per compared or size-mismatched frame
// csr       in         csr_write            csr_index selects, csr_data carries the value
//
// Pixels within a frame are taken one per cycle while the result queue has room.
// After a frame's last word the input stalls while the frame decision is
// made and fed back to the bank select.
// Reset is synchronous; the frame banks are not cleared and need no clearing pass.
// A stalled result waits in its output register while later pixels keep flowing.
`default_nettype none

`include "frame_change_mse_detector_top_macros.svh"

module frame_change_mse_detector_top
   import fcmd_pkg::*;
#(
   parameter int MAX_PIXELS = DEF_MAX_PIXELS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fcmd_req_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fcmd_rsp_type         rsp_word,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [THR_W-1:0] thr_ff, thr_in;
   logic [COUNT_W-1:0] fp_ff, fp_in;

   logic push;
   fcmd_entry_type push_entry;
   logic pop;
   fcmd_entry_type queue_head;
   logic queue_valid;
   logic [CNT_W-1:0] queue_count;
   fcmd_done_type done;

   always_comb begin
      thr_in = thr_ff;
      fp_in = fp_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CHANGE_THRESHOLD: thr_in = csr_data[THR_W-1:0];
            CSR_FRAME_PIXELS: fp_in = csr_data[COUNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         fp_ff <= FRAME_PIXELS_RESET;
      end else begin
         thr_ff <= thr_in;
         fp_ff <= fp_in;
      end
   end

   fcmd_front #(
      .MAX_PIXELS (MAX_PIXELS),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .frame_pixels(fp_ff),
      .queue_count (queue_count),
      .done        (done),
      .push        (push),
      .push_entry  (push_entry)
   );

   fcmd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (queue_head),
      .not_empty (queue_valid),
      .count     (queue_count)
   );

   fcmd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_valid     (queue_valid),
      .queue_head      (queue_head),
      .pop             (pop),
      .change_threshold(thr_ff),
      .frame_pixels    (fp_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word        (rsp_word),
      .done            (done)
   );

   `FCMD_ASSERT_NEXT(a_frame_end_holds_input, req_valid && !req_stall && req_word.end_of_frame, req_stall, "A word was taken before the frame decision was made.")
   `FCMD_ASSERT_NOW(a_similar_within_limit, rsp_valid && rsp_word.frame_similar, !rsp_word.size_mismatch && (38'(rsp_word.error_sum) <= 38'(thr_ff) * 38'(fp_ff)), "A frame flagged similar breaks the error limit.")

endmodule

`default_nettype wire
